// ===== design/sbac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbac_pkg
// Shared types and constants of the shadow bitmap access classifier.
// ----------------------------------------------------------------------------
package sbac_pkg;

   localparam int WINDOW_BYTES_DEF = 1048576;
   localparam int ADDR_BITS_DEF    = 48;
   localparam int LEN_W            = 21;
   localparam int IDX_W            = 4;
   localparam int NUM_COUNTERS     = 12;
   localparam int RSP_W            = 112;

   typedef enum logic [2:0] {
      MODE_READ  = 3'd0,
      MODE_WRITE = 3'd1,
      MODE_MARK  = 3'd2,
      MODE_CLEAR = 3'd3,
      MODE_COUNT = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      REGION_GLOBAL = 2'd0,
      REGION_HEAP   = 2'd1,
      REGION_STACK  = 2'd2,
      REGION_OTHER  = 2'd3
   } region_type;

   typedef enum logic [2:0] {
      REG_GLOBAL_LOWER = 3'd0,
      REG_GLOBAL_UPPER = 3'd1,
      REG_HEAP_LOWER   = 3'd2,
      REG_HEAP_UPPER   = 3'd3,
      REG_STACK_LOWER  = 3'd4,
      REG_STACK_UPPER  = 3'd5,
      REG_WINDOW_BASE  = 3'd6
   } reg_index_type;

   // counter slots beyond the region/direction ones
   localparam logic [3:0] CNT_HIT_BASE  = 4'd8;
   localparam logic [3:0] CNT_MISS_BASE = 4'd10;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_MOD,
      ST_DONE
   } state_type;

   // classified job handed from front to back (window offset travels alongside)
   typedef struct packed {
      logic [2:0]       mode;
      logic [1:0]       region;
      logic             walk;     // bitmap bytes must be visited
      logic [LEN_W-1:0] len;
      logic [IDX_W-1:0] idx;
   } job_type;

endpackage

// ===== design/sbac_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbac_front
// Register file, range classifier and two-entry job queue.
// ----------------------------------------------------------------------------
module sbac_front
   import sbac_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int REQ_W     = 80
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [ADDR_BITS-1:0] csr_wdata,
   input  logic                 clearing,
   output logic                 job_valid,
   input  logic                 job_ready,
   output job_type              job,
   output logic [ADDR_BITS-1:0] job_off
);

   logic [ADDR_BITS-1:0] regs_ff [7];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) regs_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_GLOBAL_LOWER: regs_ff[0] <= csr_wdata;
            REG_GLOBAL_UPPER: regs_ff[1] <= csr_wdata;
            REG_HEAP_LOWER:   regs_ff[2] <= csr_wdata;
            REG_HEAP_UPPER:   regs_ff[3] <= csr_wdata;
            REG_STACK_LOWER:  regs_ff[4] <= csr_wdata;
            REG_STACK_UPPER:  regs_ff[5] <= csr_wdata;
            REG_WINDOW_BASE:  regs_ff[6] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [2:0]           in_mode;
   logic [ADDR_BITS-1:0] in_addr;
   logic [LEN_W-1:0]     in_len;
   logic [IDX_W-1:0]     in_idx;
   logic                 is_access;
   logic [1:0]           cls;
   job_type              new_job;

   assign in_mode   = req_tdata[2:0];
   assign in_addr   = req_tdata[3 +: ADDR_BITS];
   assign in_len    = req_tdata[3 + ADDR_BITS +: LEN_W];
   assign in_idx    = req_tdata[3 + ADDR_BITS + LEN_W +: IDX_W];
   assign is_access = (in_mode == MODE_READ) || (in_mode == MODE_WRITE);

   always_comb begin
      if (regs_ff[1] > in_addr && in_addr > regs_ff[0])      cls = REGION_GLOBAL;
      else if (regs_ff[3] > in_addr && in_addr > regs_ff[2]) cls = REGION_HEAP;
      else if (regs_ff[5] > in_addr && in_addr > regs_ff[4]) cls = REGION_STACK;
      else                                                   cls = REGION_OTHER;
   end

   always_comb begin
      new_job.mode   = in_mode;
      new_job.region = is_access ? cls : REGION_GLOBAL;
      new_job.walk   = (is_access && cls == REGION_HEAP) ||
                       in_mode == MODE_MARK || in_mode == MODE_CLEAR;
      new_job.len    = in_len;
      new_job.idx    = in_idx;
   end

   // two-entry queue
   job_type              q_job_ff [2];
   logic [ADDR_BITS-1:0] q_off_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           count_ff;
   logic                 push, pop;

   assign req_tready = (count_ff != 2'd2) && !clearing;
   assign push       = req_tvalid && req_tready;
   assign job_valid  = (count_ff != 2'd0);
   assign pop        = job_valid && job_ready;
   assign job        = q_job_ff[rd_ptr_ff];
   assign job_off    = q_off_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_job_ff[wr_ptr_ff] <= new_job;
         q_off_ff[wr_ptr_ff] <= in_addr - regs_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== design/sbac_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbac_back
// Bitmap memory walker, access counters and result register.
// ----------------------------------------------------------------------------
module sbac_back
   import sbac_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  job_type              job,
   input  logic [ADDR_BITS-1:0] job_off,
   output logic                 clearing,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata
);

   localparam int MAP_BYTES = (WINDOW_BYTES + 7) / 8;
   localparam int MAP_IDX_W = $clog2(MAP_BYTES);

   state_type            state_ff, state_in;
   job_type              job_ff, job_in;
   logic [ADDR_BITS-1:0] off_ff, off_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     hits_ff, hits_in;
   logic [MAP_IDX_W-1:0] clr_ff, clr_in;
   logic [63:0]          cnt_ff [NUM_COUNTERS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [7:0]           mem [MAP_BYTES];
   logic [7:0]           rdata_ff;
   logic                 mem_re, mem_we;
   logic [MAP_IDX_W-1:0] mem_addr;
   logic [7:0]           mem_wdata;

   logic [2:0]  lo;
   logic [3:0]  room, n, hi;
   logic [7:0]  bmask;
   logic        inwin, is_access, out_free, wr;
   logic [LEN_W-1:0] misses;

   assign lo        = off_ff[2:0];
   assign room      = 4'd8 - {1'b0, lo};
   assign n         = (rem_ff < LEN_W'(room)) ? rem_ff[3:0] : room;
   assign hi        = {1'b0, lo} + n;
   assign inwin     = off_ff < ADDR_BITS'(WINDOW_BYTES);
   assign is_access = (job_ff.mode == MODE_READ) || (job_ff.mode == MODE_WRITE);
   assign wr        = job_ff.mode[0];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign misses    = job_ff.len - hits_ff;
   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      for (int j = 0; j < 8; j++)
         bmask[j] = (4'(j) >= {1'b0, lo}) && (4'(j) < hi);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == MAP_IDX_W'(MAP_BYTES - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (job_valid) state_in = ST_RD;
         ST_RD: begin
            if (rem_ff == '0)  state_in = ST_DONE;
            else if (inwin)    state_in = ST_MOD;
         end
         ST_MOD:   state_in = ST_RD;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      job_in       = job_ff;
      off_in       = off_ff;
      rem_in       = rem_ff;
      hits_in      = hits_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      job_ready    = 1'b0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = off_ff[MAP_IDX_W+2:3];
      mem_wdata    = rdata_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = 8'h00;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               job_in  = job;
               off_in  = job_off;
               rem_in  = job.walk ? job.len : '0;
               hits_in = '0;
            end
         end
         ST_RD: begin
            if (rem_ff != '0) begin
               if (inwin) begin
                  mem_re = 1'b1;
               end else begin
                  off_in = off_ff + ADDR_BITS'(n);
                  rem_in = rem_ff - LEN_W'(n);
               end
            end
         end
         ST_MOD: begin
            if (is_access) hits_in = hits_ff + LEN_W'($countones(rdata_ff & bmask));
            if (job_ff.mode == MODE_MARK) begin
               mem_we    = 1'b1;
               mem_wdata = rdata_ff | bmask;
            end else if (job_ff.mode == MODE_CLEAR) begin
               mem_we    = 1'b1;
               mem_wdata = rdata_ff & ~bmask;
            end
            off_in = off_ff + ADDR_BITS'(n);
            rem_in = rem_ff - LEN_W'(n);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (is_access) begin
                  rsp_data_in[1:0] = job_ff.region;
                  if (job_ff.region == REGION_HEAP) begin
                     rsp_data_in[2 +: LEN_W]         = hits_ff;
                     rsp_data_in[2 + LEN_W +: LEN_W] = misses;
                  end
               end else if (job_ff.mode == MODE_COUNT &&
                            job_ff.idx < IDX_W'(NUM_COUNTERS)) begin
                  rsp_data_in[2 + 2*LEN_W +: 64] = cnt_ff[job_ff.idx];
               end
            end
         end
         default: ;
      endcase
   end

   // counters: each adds its own increment on completion of an access
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COUNTERS; k++) cnt_ff[k] <= '0;
      end else if (state_ff == ST_DONE && out_free && is_access) begin
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            if (4'(k) == {1'b0, job_ff.region, wr})
               cnt_ff[k] <= cnt_ff[k] + 64'(job_ff.len);
            else if (job_ff.region == REGION_HEAP && 4'(k) == (CNT_HIT_BASE | {3'b0, wr}))
               cnt_ff[k] <= cnt_ff[k] + 64'(hits_ff);
            else if (job_ff.region == REGION_HEAP && 4'(k) == (CNT_MISS_BASE | {3'b0, wr}))
               cnt_ff[k] <= cnt_ff[k] + 64'(misses);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      off_ff      <= off_in;
      rem_ff      <= rem_in;
      hits_ff     <= hits_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a modify step always follows its read
   a_mod_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOD |-> $past(state_ff) == ST_RD)
      else $error("modify without read");

   // each walk step consumes bytes
   a_rem_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD && $past(state_ff) == ST_MOD) |-> rem_ff < $past(rem_ff))
      else $error("walk made no progress");

   // hit count never exceeds the access length
   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> hits_ff <= job_ff.len)
      else $error("hits exceed length");

   // no beat is taken from the queue while clearing
   a_no_job_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !job_ready)
      else $error("job taken during clear");

endmodule

// ===== design/shadow_bitmap_access_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_bitmap_access_classifier_core
// Allocation bitmap with region classifier and access counters.
// ----------------------------------------------------------------------------
// After reset the bitmap memory is swept clear, one byte per cycle, over all
// (WINDOW_BYTES+7)/8 bytes (131072 at the default); req_tready stays low during
// the sweep while csr writes are taken as usual. A front end classifies each
// request beat against the region bounds, computes its window offset and
// queues it (two entries); a back end walks the bitmap one memory byte per
// step and returns one rsp beat per request. Each in-window bitmap byte
// touched is read then modified/written on the single memory port, and each
// out-of-window byte group is skipped without a memory access; heap accesses,
// marks and clears walk the bitmap, while non-heap accesses and counter
// reads touch no bitmap byte. A stalled rsp side holds the back end in its
// final state.
// Counters wrap at 2^64.
// ----------------------------------------------------------------------------
module shadow_bitmap_access_classifier_core
   import sbac_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // req_tdata: mode[3], address[ADDR_BITS], length[21], counter_index[4], zero pad
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [((28 + ADDR_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // rsp_tdata: region[2], allocated_bytes[21], unallocated_bytes[21],
   //            counter_value[64], zero pad
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,
   // register write port
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [ADDR_BITS-1:0] csr_wdata
);

   localparam int REQ_W = ((28 + ADDR_BITS + 7) / 8) * 8;

   logic                 clearing;
   logic                 job_valid, job_ready;
   job_type              job;
   logic [ADDR_BITS-1:0] job_off;

   sbac_front #(
      .ADDR_BITS (ADDR_BITS),
      .REQ_W     (REQ_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .clearing   (clearing),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .job_off    (job_off)
   );

   sbac_back #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .job_off    (job_off),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
